// ===== rtl/core/frame_flip_rotate_macros.svh =====
// Assertion macros shared by the frame_flip_rotate RTL.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef FRAME_FLIP_ROTATE_MACROS_SVH
`define FRAME_FLIP_ROTATE_MACROS_SVH

// Property checked at every clock edge outside reset.
`define FFR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define FFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ffr_pkg.sv =====
// Shared types and constants of the frame flip/rotate block.
// No dependencies; used by ffr_ctrl, ffr_dp and frame_flip_rotate.
package ffr_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 9'd256;

  // input item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  typedef enum logic [1:0] {
    MODE_MIRROR_X  = 2'd0,
    MODE_MIRROR_Y  = 2'd1,
    MODE_ROT_LEFT  = 2'd2,
    MODE_ROT_RIGHT = 2'd3
  } mode_e;

  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             last;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_wr;   // write accepted pixel at load position
    logic pos_step;  // map output position to source row/col
    logic addr_step; // form linear store address
    logic rd_en;     // issue store read
    logic out_load;  // capture read data into output register
  } cmd_t;

endpackage

// ===== rtl/core/ffr_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per transfer.
// Payload type is set per instance; no other dependencies.
interface ffr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/ffr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ffr_ctrl.sv =====
// Sequencer of the frame flip/rotate block: input/output handshakes, commands.
// Depends on ffr_pkg and frame_flip_rotate_macros.svh.
`include "frame_flip_rotate_macros.svh"

module ffr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_func_i,
  input  logic          out_ready_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output ffr_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POS  = 3'd1;
  localparam logic [2:0] S_ADDR = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_DATA = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_xfer;
  logic       fetch_xfer;
  logic       data_wait;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_func_i == ffr_pkg::FUNC_LOAD) begin
            cmd_o.load_wr = 1'b1;
          end else begin
            state_d = S_POS;
          end
        end
      end
      S_POS: begin
        cmd_o.pos_step = 1'b1;
        state_d        = S_ADDR;
      end
      S_ADDR: begin
        cmd_o.addr_step = 1'b1;
        state_d         = S_READ;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_DATA;
      end
      S_DATA: begin
        // wait here until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  assign fetch_xfer = in_xfer && (in_func_i == ffr_pkg::FUNC_FETCH);
  assign data_wait  = (state_q == S_DATA) && out_valid_q && !out_ready_i;

  `FFR_ASSERT_NEXT(a_fetch_starts, clk_i, rst_ni, fetch_xfer, state_q == S_POS, "no pos step")
  `FFR_ASSERT_NEXT(a_read_data, clk_i, rst_ni, state_q == S_READ, state_q == S_DATA, "read lost")
  `FFR_ASSERT(a_one_cmd, clk_i, rst_ni, $onehot0(cmd_o), "more than one datapath command at once")
  `FFR_ASSERT_NEXT(a_hold, clk_i, rst_ni, data_wait, state_q == S_DATA && out_valid_q, "lost")

endmodule

// ===== rtl/core/ffr_dp.sv =====
// Datapath of the frame flip/rotate block: config registers, counters,
// address generation, frame store and output register. Depends on ffr_pkg, ffr_ram.
module ffr_dp #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ffr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ffr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  ffr_pkg::in_item_t                in_data_i,
  input  ffr_pkg::cmd_t                    cmd_i,
  output ffr_pkg::out_item_t               out_data_o
);

  localparam int unsigned MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned DW      = $clog2(MAX_DIM + 1);
  localparam int unsigned PW      = $clog2(MAX_DIM);
  localparam int unsigned DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned TW      = $clog2(DEPTH + 1);
  localparam int unsigned LW      = PW + DW;
  localparam int unsigned PXW     = 3 * ffr_pkg::PIX_W;

  ffr_pkg::mode_e                 mode_q;
  logic [ffr_pkg::CFG_DATA_W-1:0] cfg_width_q, cfg_height_q;

  logic [DW-1:0]   w, h, ow, oh;
  logic [2*DW-1:0] area;
  logic [TW-1:0]   total;
  logic            rot;

  logic [AW-1:0] lc_q, lc_d, lc_start;
  logic [TW-1:0] lc_inc;

  logic [PW-1:0] row_q, row_d, col_q, col_d;
  logic [PW-1:0] r, c, sr, sc;
  logic [PW-1:0] sr_q, sc_q;
  logic [DW-1:0] col_inc, row_inc;
  logic          wrap, is_last;
  logic          last_q, last_out_q;
  logic [LW-1:0] lin;
  logic [AW-1:0] addr_q;

  logic [PXW-1:0] rdata;
  logic [PXW-1:0] pix_out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ffr_pkg::MODE_MIRROR_X;
      cfg_width_q  <= ffr_pkg::DIM_RESET;
      cfg_height_q <= ffr_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ffr_pkg::CFG_MODE:   mode_q       <= ffr_pkg::mode_e'(cfg_wdata_i[1:0]);
        ffr_pkg::CFG_WIDTH:  cfg_width_q  <= cfg_wdata_i;
        ffr_pkg::CFG_HEIGHT: cfg_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // zero is taken as 1, oversize as the maximum
  assign w = (cfg_width_q == '0) ? DW'(1) :
             (32'(cfg_width_q) > 32'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(cfg_width_q);
  assign h = (cfg_height_q == '0) ? DW'(1) :
             (32'(cfg_height_q) > 32'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(cfg_height_q);

  assign area  = (2*DW)'(w) * (2*DW)'(h);
  assign total = TW'(area);
  assign rot   = (mode_q == ffr_pkg::MODE_ROT_LEFT) || (mode_q == ffr_pkg::MODE_ROT_RIGHT);
  assign ow    = rot ? h : w;
  assign oh    = rot ? w : h;

  // load position, restarts when it lies beyond the current frame
  assign lc_start = (TW'(lc_q) >= total) ? '0 : lc_q;
  assign lc_inc   = TW'(lc_start) + TW'(1);
  assign lc_d     = (lc_inc >= total) ? '0 : AW'(lc_inc);

  // output position to source row/col
  always_comb begin
    wrap    = (DW'(row_q) >= oh) || (DW'(col_q) >= ow);
    r       = wrap ? '0 : row_q;
    c       = wrap ? '0 : col_q;
    is_last = (DW'(r) == oh - DW'(1)) && (DW'(c) == ow - DW'(1));
    col_inc = DW'(c) + DW'(1);
    row_inc = DW'(r) + DW'(1);
    if (col_inc >= ow) begin
      col_d = '0;
      row_d = (row_inc >= oh) ? '0 : PW'(row_inc);
    end else begin
      col_d = PW'(col_inc);
      row_d = r;
    end
    case (mode_q)
      ffr_pkg::MODE_MIRROR_X: begin
        sr = r;
        sc = PW'(w - DW'(1) - DW'(c));
      end
      ffr_pkg::MODE_MIRROR_Y: begin
        sr = PW'(h - DW'(1) - DW'(r));
        sc = c;
      end
      ffr_pkg::MODE_ROT_LEFT: begin
        sr = c;
        sc = PW'(w - DW'(1) - DW'(r));
      end
      default: begin
        sr = PW'(h - DW'(1) - DW'(c));
        sc = r;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q  <= '0;
      row_q <= '0;
      col_q <= '0;
    end else begin
      if (cmd_i.load_wr) begin
        lc_q <= lc_d;
      end
      if (cmd_i.pos_step) begin
        row_q <= row_d;
        col_q <= col_d;
      end
    end
  end

  assign lin = LW'(sr_q) * LW'(w) + LW'(sc_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_step) begin
      sr_q   <= sr;
      sc_q   <= sc;
      last_q <= is_last;
    end
    if (cmd_i.addr_step) begin
      addr_q <= AW'(lin);
    end
    if (cmd_i.out_load) begin
      pix_out_q  <= rdata;
      last_out_q <= last_q;
    end
  end

  ffr_ram #(
    .WIDTH (PXW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_wr),
    .waddr_i (lc_start),
    .wdata_i ({in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign out_data_o.red_out   = pix_out_q[PXW-1 -: ffr_pkg::PIX_W];
  assign out_data_o.green_out = pix_out_q[2*ffr_pkg::PIX_W-1 -: ffr_pkg::PIX_W];
  assign out_data_o.blue_out  = pix_out_q[ffr_pkg::PIX_W-1:0];
  assign out_data_o.last      = last_out_q;

endmodule

// ===== rtl/core/frame_flip_rotate.sv =====
// Frame flip/rotate: frame store of RGB pixels with mirror and 90-degree rotate readout.
// Depends on ffr_pkg, ffr_stream_if, ffr_ctrl, ffr_dp, ffr_ram.
//
// Usage:
//   in_i carries items with func = load (store one pixel in raster order of the
//   loaded frame, no result) or func = fetch (return the next pixel of the
//   transformed frame, raster order of the output size; last flags its end).
//   out_o delivers one item per fetch through an output register.
//   Config (mode, img_width, img_height) is written through cfg_we_i/cfg_idx_i/
//   cfg_wdata_i while the block is idle. Load a full frame before fetching.
// Sequence:
//   A load leaves the block idle; in_i.ready stays high between loads, one per clock
//   while no fetch is in progress. A fetch occupies the block through transfer,
//   position mapping, address multiply-add, registered store read and output
//   capture; the result is valid once captured into the output register.
// Reset clears the counters, the output register valid and the config
// (mode mirror columns, 256 x 256); the store content is undefined until loaded.
// A stalled receiver holds the result; loads are still taken, and the next fetch
// runs to its capture step and waits there, input held off, until the output is free.
module frame_flip_rotate #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ffr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ffr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  ffr_stream_if.sink                     in_i,
  ffr_stream_if.source                   out_o
);

  ffr_pkg::cmd_t      cmd;
  ffr_pkg::in_item_t  in_data;
  ffr_pkg::out_item_t out_data;
  logic               in_ready;
  logic               out_valid;

  assign in_data = in_i.data;

  ffr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_func_i   (in_data.func),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  ffr_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data),
    .cmd_i       (cmd),
    .out_data_o  (out_data)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

endmodule
